// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// next-cycle implication, disabled during reset
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

// ----- sv/pgs_pkg.sv -----
// shared types and constants for the polar gaussian sampler
// no dependencies
package pgs_pkg;

	localparam int UNIFORM_BITS     = 16;
	localparam int SAMPLE_FRAC_BITS = 12;
	localparam int LOG_FRAC         = 28;
	localparam int TWOF             = 2 * (UNIFORM_BITS - 1);
	localparam int Y_SHIFT          = 2 * LOG_FRAC - 2 * SAMPLE_FRAC_BITS;
	localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
	localparam logic [15:0] HALF    = 16'h8000;

	// one accepted pair: squared magnitudes, signs and w
	typedef struct packed {
		logic [29:0] sq1;
		logic [29:0] sq2;
		logic        neg1;
		logic        neg2;
		logic [29:0] w;
	} pgs_pair_t;

endpackage

// ----- sv/pgs_front.sv -----
// front end: takes uniform pairs, forms w and drops rejected pairs
// depends on pgs_pkg
module pgs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       first_uniform,
	input  logic [15:0]       second_uniform,
	output logic              push,
	input  logic              full,
	output pgs_pkg::pgs_pair_t pair
);
	import pgs_pkg::*;

	logic        valid_s1;
	logic        neg1_s1, neg2_s1;
	logic [15:0] a1_s1, a2_s1;
	logic [31:0] sq1, sq2;
	logic [32:0] w;
	logic        reject;
	logic        drain;

	assign sq1    = a1_s1 * a1_s1;
	assign sq2    = a2_s1 * a2_s1;
	assign w      = {1'b0, sq1} + {1'b0, sq2};
	assign reject = (w == '0) || (w >= (33'd1 << TWOF));
	assign push   = valid_s1 && !reject && !full;
	assign drain  = valid_s1 && (reject || !full);
	assign in_ready = !valid_s1 || drain;

	assign pair.sq1  = sq1[29:0];
	assign pair.sq2  = sq2[29:0];
	assign pair.neg1 = neg1_s1;
	assign pair.neg2 = neg2_s1;
	assign pair.w    = w[29:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			neg1_s1 <= first_uniform < HALF;
			neg2_s1 <= second_uniform < HALF;
			a1_s1 <= (first_uniform < HALF) ? HALF - first_uniform : first_uniform - HALF;
			a2_s1 <= (second_uniform < HALF) ? HALF - second_uniform : second_uniform - HALF;
		end
	end

endmodule

// ----- sv/pgs_queue.sv -----
// two-entry queue between front and back end
// depends on pgs_pkg
module pgs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pgs_pkg::pgs_pair_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output pgs_pkg::pgs_pair_t pop_data
);
	import pgs_pkg::*;

	pgs_pair_t  mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ----- sv/pgs_back.sv -----
// back end: sequencer for log, divide, multiply and root, plus output register
// depends on pgs_pkg
module pgs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	output logic               pop,
	input  pgs_pkg::pgs_pair_t pop_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] normal_sample,
	output logic               is_second
);
	import pgs_pkg::*;

	typedef enum logic [3:0] {
		B_IDLE, B_NORM, B_LOG, B_NMUL1, B_NMUL2,
		B_DIV, B_YMUL1, B_YMUL2, B_SQRT, B_OUT
	} state_t;

	state_t      state_q;
	pgs_pair_t   ent_q;
	logic [29:0] m_q;
	logic [4:0]  k_q;
	logic [27:0] frac_q;
	logic [4:0]  cnt_q;
	logic [33:0] n_q;
	logic [45:0] plo_q;
	logic        sel_q;
	logic [30:0] rem_q;
	logic [28:0] q_q;
	logic [33:0] sv_q;
	logic [19:0] srem_q;
	logic [16:0] sres_q;

	logic [59:0] msq;
	logic [29:0] m2;
	logic [32:0] lval;
	logic [44:0] nhi;
	logic [45:0] yhi;
	logic [61:0] nprod;
	logic [62:0] yprod;
	logic [30:0] y2;
	logic        ge;
	logic [30:0] rem_sub;
	logic [19:0] r2, trial;
	logic [17:0] mag;
	logic [15:0] sample;
	logic        neg;
	logic        slot_free;

	assign msq   = m_q * m_q;
	assign m2    = msq[LOG_FRAC +: 30];
	assign lval  = {k_q, 28'b0} - {5'b0, frac_q};
	assign nhi   = lval[32:17] * TWO_LN2_Q28;
	assign nprod = ({17'b0, nhi} << 17) + {16'b0, plo_q};
	assign yhi   = n_q[33:17] * q_q;
	assign yprod = ({17'b0, yhi} << 17) + {17'b0, plo_q};
	assign y2    = yprod[Y_SHIFT +: 31];
	assign ge    = rem_q >= {1'b0, ent_q.w};
	assign rem_sub = ge ? rem_q - {1'b0, ent_q.w} : rem_q;
	assign r2    = {srem_q[17:0], sv_q[33:32]};
	assign trial = {1'b0, sres_q, 2'b01};
	assign mag   = ({1'b0, sres_q} + 18'd1) >> 1;
	assign neg   = sel_q ? ent_q.neg2 : ent_q.neg1;
	assign sample = neg ? (16'd0 - ((mag > 18'd32768) ? 16'h8000 : mag[15:0]))
	                    : ((mag > 18'd32767) ? 16'h7fff : mag[15:0]);
	assign slot_free = !out_valid || out_ready;
	assign pop = (state_q == B_IDLE) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			out_valid <= 1'b0;
			cnt_q     <= '0;
			sel_q     <= 1'b0;
		end else begin
			if ((state_q == B_OUT) && slot_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!empty) state_q <= B_NORM;
				end
				B_NORM: begin
					if (m_q[29] || m_q[28]) begin
						state_q <= B_LOG;
						cnt_q   <= 5'd27;
					end
				end
				B_LOG: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_q <= B_NMUL1;
				end
				B_NMUL1: state_q <= B_NMUL2;
				B_NMUL2: begin
					state_q <= B_DIV;
					sel_q   <= 1'b0;
					cnt_q   <= 5'd28;
				end
				B_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_q <= B_YMUL1;
				end
				B_YMUL1: state_q <= B_YMUL2;
				B_YMUL2: begin
					state_q <= B_SQRT;
					cnt_q   <= 5'd16;
				end
				B_SQRT: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_q <= B_OUT;
				end
				B_OUT: begin
					if (slot_free) begin
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= B_DIV;
							cnt_q   <= 5'd28;
						end else begin
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				ent_q  <= pop_data;
				m_q    <= pop_data.w;
				k_q    <= 5'd2;
				frac_q <= '0;
			end
			B_NORM: begin
				if (m_q[29]) begin
					m_q <= m_q >> 1;
					k_q <= 5'd1;
				end else if (!m_q[28]) begin
					m_q <= m_q << 1;
					k_q <= k_q + 5'd1;
				end
			end
			B_LOG: begin
				frac_q <= {frac_q[26:0], m2[29]};
				m_q    <= m2[29] ? m2 >> 1 : m2;
			end
			B_NMUL1: plo_q <= lval[16:0] * TWO_LN2_Q28;
			B_NMUL2: begin
				n_q   <= nprod[LOG_FRAC +: 34];
				rem_q <= {1'b0, ent_q.sq1};
				q_q   <= '0;
			end
			B_DIV: begin
				q_q   <= {q_q[27:0], ge};
				rem_q <= {rem_sub[29:0], 1'b0};
			end
			B_YMUL1: plo_q <= n_q[16:0] * q_q;
			B_YMUL2: begin
				sv_q   <= {1'b0, y2, 2'b00};
				srem_q <= '0;
				sres_q <= '0;
			end
			B_SQRT: begin
				sv_q <= sv_q << 2;
				if (r2 >= trial) begin
					srem_q <= r2 - trial;
					sres_q <= {sres_q[15:0], 1'b1};
				end else begin
					srem_q <= r2;
					sres_q <= {sres_q[15:0], 1'b0};
				end
			end
			B_OUT: begin
				if (slot_free) begin
					normal_sample <= sample;
					is_second     <= sel_q;
					rem_q <= {1'b0, ent_q.sq2};
					q_q   <= '0;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- sv/polar_gaussian_sampler.sv -----
// path per pair: front register, queue, normalize, log, scale, then per sample
//   divide, multiply and root; the single shared back end takes no new pair until
//   both samples are out (one log squaring, quotient bit or root digit per cycle)
// the front takes a new pair each cycle until the two-entry queue fills; rejected pairs
//   are dropped in the front and cost the back end nothing
// reset: arst_n asynchronous, clears queue, state and output valid; no sweep needed
module polar_gaussian_sampler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        first_uniform,
	input  logic [15:0]        second_uniform,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] normal_sample,
	output logic               is_second
);
	import pgs_pkg::*;

	// front to queue
	pgs_pair_t push_data;
	logic      push, full;
	// queue to back
	pgs_pair_t pop_data;
	logic      pop, empty;

	// squares, w and the reject test
	pgs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_uniform  (first_uniform),
		.second_uniform (second_uniform),
		.push           (push),
		.full           (full),
		.pair           (push_data)
	);

	// decouples the front from the long back-end run
	pgs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.pop_data  (pop_data)
	);

	// log, scale, per-sample divide and root, then the output register
	pgs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (empty),
		.pop           (pop),
		.pop_data      (pop_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.normal_sample (normal_sample),
		.is_second     (is_second)
	);

endmodule

// ----- sv/pgs_checker.sv -----
// port-level checker for the sampler, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module pgs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [15:0]       first_uniform,
	input logic [15:0]       second_uniform,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [15:0] normal_sample,
	input logic              is_second
);
	// set after a first sample leaves, cleared after its partner
	logic expect_second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_second_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			expect_second_q <= !is_second;
		end
	end

	`CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(normal_sample) && $stable(is_second))
	`CHK_SAME(a_second_follows, out_valid && is_second, expect_second_q)
	`CHK_SAME(a_first_fresh, out_valid && !is_second, !expect_second_q)
	`CHK_SAME(a_in_known, in_valid && in_ready, !$isunknown(first_uniform) && !$isunknown(second_uniform))

endmodule

bind polar_gaussian_sampler pgs_checker u_pgs_checker (.*);
